// ----- hdl/mpa_pkg.sv -----
// Shared types, widths and register codes for the max pooling block.
// Used by max_pool_argmax; depends on nothing else.
`default_nettype none

package mpa_pkg;

    // Size limits of the supported maps.
    localparam int MAX_WIDTH    = 256;
    localparam int MAX_HEIGHT   = 256;
    localparam int MAX_CHANNELS = 64;
    localparam int MAX_POOL     = 8;

    // Field and counter widths.
    localparam int DATA_W     = 16;
    localparam int IDX_W      = 22;
    localparam int COL_W      = 8;
    localparam int ROW_W      = 8;
    localparam int CHAN_W     = 6;
    localparam int PHASE_W    = 3;
    localparam int POOL_W     = 4;
    localparam int DIM_W      = 9;
    localparam int CHCNT_W    = 7;
    localparam int CFG_ADDR_W = 8;
    localparam int CFG_DATA_W = 9;
    localparam int OUT_TDATA_W = 40;

    // Configuration register indexes.
    localparam logic [CFG_ADDR_W-1:0] REG_POOL_SIZE     = 8'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_FRAME_HEIGHT  = 8'd1;
    localparam logic [CFG_ADDR_W-1:0] REG_FRAME_WIDTH   = 8'd2;
    localparam logic [CFG_ADDR_W-1:0] REG_CHANNEL_COUNT = 8'd3;

    // One entry of the band store: running maximum and where it came from.
    typedef struct packed {
        logic [IDX_W-1:0]  index;
        logic [DATA_W-1:0] value;
    } entry_t;

    localparam int ENTRY_W = $bits(entry_t);

    // Saturate a written window size into 1..MAX_POOL.
    function automatic logic [POOL_W-1:0] clamp_pool(input logic [POOL_W-1:0] v);
        logic [POOL_W-1:0] r;
        r = v;
        if (v == '0)
            r = POOL_W'(1);
        else if (v > POOL_W'(MAX_POOL))
            r = POOL_W'(MAX_POOL);
        return r;
    endfunction

    // Saturate a written frame dimension into 1..lim.
    function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v,
                                                   input logic [DIM_W-1:0] lim);
        logic [DIM_W-1:0] r;
        r = v;
        if (v == '0)
            r = DIM_W'(1);
        else if (v > lim)
            r = lim;
        return r;
    endfunction

    // Saturate a written channel count into 1..MAX_CHANNELS.
    function automatic logic [CHCNT_W-1:0] clamp_chan(input logic [CHCNT_W-1:0] v);
        logic [CHCNT_W-1:0] r;
        r = v;
        if (v == '0)
            r = CHCNT_W'(1);
        else if (v > CHCNT_W'(MAX_CHANNELS))
            r = CHCNT_W'(MAX_CHANNELS);
        return r;
    endfunction

endpackage

`default_nettype wire

// ----- hdl/mpa_ram.sv -----
// Generic single-port-write, single-port-read RAM with registered read data.
// Stand-alone; holds no reset state.
`default_nettype none

module mpa_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // A read in the same cycle as a write to that address returns the old word.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

// ----- hdl/max_pool_argmax.sv -----
// Streaming KxK max pooling with argmax over a channel/row/column raster.
// A result passes through the work stage and then the output register.
// Throughput: one pixel word per cycle while the output is not stalled; the band store
// is read on accept and written as the pixel leaves the work stage, newest write forwarded.
// Reset: rst_n clears all position counters and handshake state and loads the
// default registers (K=2, 256x256, one channel); the band store is not cleared.
// Depends on mpa_pkg and mpa_ram.
`default_nettype none

module max_pool_argmax (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    // Pixel input; s_tdata: pixel_value[15:0]
    input  wire logic                              s_tvalid,
    output logic                                   s_tready,
    input  wire logic [mpa_pkg::DATA_W-1:0]        s_tdata,
    // Pooled output; m_tdata: pooled_value[15:0], winner_index[37:16], zero[39:38]
    output logic                                   m_tvalid,
    input  wire logic                              m_tready,
    output logic      [mpa_pkg::OUT_TDATA_W-1:0]   m_tdata,
    output logic                                   m_tlast,
    // Configuration writes
    input  wire logic                              cfg_valid,
    output logic                                   cfg_ready,
    input  wire logic [mpa_pkg::CFG_ADDR_W-1:0]    cfg_addr,
    input  wire logic [mpa_pkg::CFG_DATA_W-1:0]    cfg_data
);

    localparam int ADDR_W = $clog2(mpa_pkg::MAX_WIDTH);

    // Configuration registers.
    logic [mpa_pkg::POOL_W-1:0]  pool_size_reg;
    logic [mpa_pkg::DIM_W-1:0]   frame_height_reg;
    logic [mpa_pkg::DIM_W-1:0]   frame_width_reg;
    logic [mpa_pkg::CHCNT_W-1:0] channel_count_reg;
    logic                        restart;

    // Position of the next pixel.
    logic [mpa_pkg::COL_W-1:0]   col_reg;
    logic [mpa_pkg::ROW_W-1:0]   row_reg;
    logic [mpa_pkg::CHAN_W-1:0]  chan_reg;
    logic [mpa_pkg::PHASE_W-1:0] col_phase_reg;
    logic [mpa_pkg::PHASE_W-1:0] row_phase_reg;
    logic [ADDR_W-1:0]           ocol_reg;
    logic [mpa_pkg::IDX_W-1:0]   flat_reg;

    // Work stage holding one accepted pixel.
    logic                        s1_valid_reg;
    logic signed [mpa_pkg::DATA_W-1:0] s1_value_reg;
    logic [mpa_pkg::IDX_W-1:0]   s1_index_reg;
    logic [ADDR_W-1:0]           s1_ocol_reg;
    logic                        s1_seed_reg;
    logic                        s1_emit_reg;
    logic                        s1_last_reg;

    // Most recent band store write, forwarded to the next read.
    logic                        lw_valid_reg;
    logic [ADDR_W-1:0]           lw_addr_reg;
    mpa_pkg::entry_t             lw_entry_reg;

    // Output register.
    logic                        out_valid_reg;
    mpa_pkg::entry_t             out_entry_reg;
    logic                        out_last_reg;

    logic                        accept;
    logic                        fire;
    logic                        out_free;
    logic                        w_last;
    logic                        h_last;
    logic                        c_last;
    logic                        cph_end;
    logic                        rph_end;
    logic                        map_last;
    mpa_pkg::entry_t             ram_q;
    mpa_pkg::entry_t             stored;
    mpa_pkg::entry_t             merged;
    logic                        take;

    assign cfg_ready = 1'b1;

    // Register writes; a known index restarts the map position.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pool_size_reg     <= mpa_pkg::POOL_W'(2);
            frame_height_reg  <= mpa_pkg::DIM_W'(mpa_pkg::MAX_HEIGHT);
            frame_width_reg   <= mpa_pkg::DIM_W'(mpa_pkg::MAX_WIDTH);
            channel_count_reg <= mpa_pkg::CHCNT_W'(1);
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_addr)
                mpa_pkg::REG_POOL_SIZE:
                    pool_size_reg <= mpa_pkg::clamp_pool(cfg_data[mpa_pkg::POOL_W-1:0]);
                mpa_pkg::REG_FRAME_HEIGHT:
                    frame_height_reg <= mpa_pkg::clamp_dim(cfg_data,
                                            mpa_pkg::DIM_W'(mpa_pkg::MAX_HEIGHT));
                mpa_pkg::REG_FRAME_WIDTH:
                    frame_width_reg <= mpa_pkg::clamp_dim(cfg_data,
                                            mpa_pkg::DIM_W'(mpa_pkg::MAX_WIDTH));
                mpa_pkg::REG_CHANNEL_COUNT:
                    channel_count_reg <= mpa_pkg::clamp_chan(
                                            cfg_data[mpa_pkg::CHCNT_W-1:0]);
                default:
                    ;
            endcase
        end
    end

    always_comb
    begin
        restart = 1'b0;
        if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_addr)
                mpa_pkg::REG_POOL_SIZE:     restart = 1'b1;
                mpa_pkg::REG_FRAME_HEIGHT:  restart = 1'b1;
                mpa_pkg::REG_FRAME_WIDTH:   restart = 1'b1;
                mpa_pkg::REG_CHANNEL_COUNT: restart = 1'b1;
                default:                    restart = 1'b0;
            endcase
        end
    end

    // Handshake: the work stage moves on when its result has somewhere to go.
    assign out_free = !out_valid_reg || m_tready;
    assign fire     = s1_valid_reg && (!s1_emit_reg || out_free);
    assign s_tready = !s1_valid_reg || fire;
    assign accept   = s_tvalid && s_tready;

    // Window and frame edges of the pixel now at the input.
    assign w_last  = ({1'b0, col_reg} + mpa_pkg::DIM_W'(1)) >= frame_width_reg;
    assign h_last  = ({1'b0, row_reg} + mpa_pkg::DIM_W'(1)) >= frame_height_reg;
    assign c_last  = ({1'b0, chan_reg} + mpa_pkg::CHCNT_W'(1)) >= channel_count_reg;
    assign cph_end = ({1'b0, col_phase_reg} + mpa_pkg::POOL_W'(1)) >= pool_size_reg;
    assign rph_end = ({1'b0, row_phase_reg} + mpa_pkg::POOL_W'(1)) >= pool_size_reg;
    assign map_last = w_last && h_last && c_last;

    // Position counters advance by one pixel on each accepted word.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg       <= '0;
            row_reg       <= '0;
            chan_reg      <= '0;
            col_phase_reg <= '0;
            row_phase_reg <= '0;
            ocol_reg      <= '0;
            flat_reg      <= '0;
        end
        else if (restart)
        begin
            col_reg       <= '0;
            row_reg       <= '0;
            chan_reg      <= '0;
            col_phase_reg <= '0;
            row_phase_reg <= '0;
            ocol_reg      <= '0;
            flat_reg      <= '0;
        end
        else if (accept)
        begin
            flat_reg <= map_last ? '0 : flat_reg + mpa_pkg::IDX_W'(1);
            if (w_last)
            begin
                col_reg       <= '0;
                col_phase_reg <= '0;
                ocol_reg      <= '0;
                if (h_last)
                begin
                    row_reg       <= '0;
                    row_phase_reg <= '0;
                    chan_reg      <= c_last ? '0 : chan_reg + mpa_pkg::CHAN_W'(1);
                end
                else
                begin
                    row_reg       <= row_reg + mpa_pkg::ROW_W'(1);
                    row_phase_reg <= rph_end ? '0 : row_phase_reg + mpa_pkg::PHASE_W'(1);
                end
            end
            else
            begin
                col_reg <= col_reg + mpa_pkg::COL_W'(1);
                if (cph_end)
                begin
                    col_phase_reg <= '0;
                    ocol_reg      <= ocol_reg + ADDR_W'(1);
                end
                else
                begin
                    col_phase_reg <= col_phase_reg + mpa_pkg::PHASE_W'(1);
                end
            end
        end
    end

    // Work stage control.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (s_tready)
        begin
            s1_valid_reg <= s_tvalid;
        end
    end

    // Work stage payload, captured with the pixel.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_value_reg <= s_tdata;
            s1_index_reg <= flat_reg;
            s1_ocol_reg  <= ocol_reg;
            s1_seed_reg  <= (col_phase_reg == '0) && (row_phase_reg == '0);
            s1_emit_reg  <= (cph_end || w_last) && (rph_end || h_last);
            s1_last_reg  <= map_last;
        end
    end

    // Band store: one entry per output column of the current band.
    mpa_ram #(
        .WIDTH (mpa_pkg::ENTRY_W),
        .DEPTH (mpa_pkg::MAX_WIDTH)
    ) u_band_store (
        .clk   (clk),
        .we    (fire),
        .waddr (s1_ocol_reg),
        .wdata (merged),
        .re    (accept),
        .raddr (ocol_reg),
        .rdata (ram_q)
    );

    // Compare against the running maximum; earlier pixel wins a tie.
    always_comb
    begin
        stored = ram_q;
        if (lw_valid_reg && (lw_addr_reg == s1_ocol_reg))
        begin
            stored = lw_entry_reg;
        end
        take = s1_seed_reg || (s1_value_reg > $signed(stored.value));
        if (take)
        begin
            merged.value = s1_value_reg;
            merged.index = s1_index_reg;
        end
        else
        begin
            merged = stored;
        end
    end

    // Keep the newest write for forwarding.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lw_valid_reg <= 1'b0;
        end
        else if (fire)
        begin
            lw_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            lw_addr_reg  <= s1_ocol_reg;
            lw_entry_reg <= merged;
        end
    end

    // Output register: loaded when a finished window leaves the work stage.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (fire && s1_emit_reg)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire && s1_emit_reg)
        begin
            out_entry_reg <= merged;
            out_last_reg  <= s1_last_reg;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{(mpa_pkg::OUT_TDATA_W - mpa_pkg::ENTRY_W){1'b0}}, out_entry_reg};
    assign m_tlast  = out_last_reg;

    // A finished window is only released into a free output register.
    a_emit_room: assert property (@(posedge clk) disable iff (!rst_n)
        (fire && s1_emit_reg) |-> out_free)
        else $error("result released while output register is occupied");

    // The last pixel of a map brings every position counter back to zero.
    a_map_wrap: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && map_last && !restart) |=>
        (col_reg == '0 && row_reg == '0 && chan_reg == '0 && flat_reg == '0))
        else $error("position counters did not wrap at end of map");

    // The column and row phases stay inside the window.
    a_phase_range: assert property (@(posedge clk) disable iff (!rst_n)
        ({1'b0, col_phase_reg} < pool_size_reg) && ({1'b0, row_phase_reg} < pool_size_reg))
        else $error("window phase out of range");

    // The output column never runs ahead of the input column.
    a_ocol_bound: assert property (@(posedge clk) disable iff (!rst_n)
        ocol_reg <= col_reg)
        else $error("output column ahead of input column");

endmodule

`default_nettype wire

// ----- verif/testbench.sv -----
// Self-checking testbench for max_pool_argmax: streams pixel words, predicts each
// pooled word with its own window tracker and compares field by field.
// Depends on mpa_pkg and the max_pool_argmax RTL.
`timescale 1ns / 100ps

module testbench;

    // Register indexes that the block does not decode.
    localparam logic [mpa_pkg::CFG_ADDR_W-1:0] REG_UNUSED_LO = 8'd4;
    localparam logic [mpa_pkg::CFG_ADDR_W-1:0] REG_UNUSED_HI = 8'hFF;

    // Cycles to let pass after the last pooled word before touching registers.
    localparam int SETTLE_CYCLES = 8;

    // Pixel words sent by the random part of the run.
    localparam int unsigned RANDOM_ITEMS = 1200;

    logic                               clk;
    logic                               rst_n;
    logic                               s_tvalid;
    logic                               s_tready;
    logic [mpa_pkg::DATA_W-1:0]         s_tdata;
    logic                               m_tvalid;
    logic                               m_tready;
    logic [mpa_pkg::OUT_TDATA_W-1:0]    m_tdata;
    logic                               m_tlast;
    logic                               cfg_valid;
    logic                               cfg_ready;
    logic [mpa_pkg::CFG_ADDR_W-1:0]     cfg_addr;
    logic [mpa_pkg::CFG_DATA_W-1:0]     cfg_data;

    int tx_idle_pct;
    int rx_idle_pct;

    // One pooled word as the block should send it.
    typedef struct {
        logic [mpa_pkg::DATA_W-1:0] value;
        logic [mpa_pkg::IDX_W-1:0]  index;
        logic                       last;
    } pooled_t;

    // Tracks window positions and running maxima, and holds the pooled words
    // still owed by the block.
    class pool_tracker;
        logic [mpa_pkg::POOL_W-1:0]        win;
        logic [mpa_pkg::DIM_W-1:0]         rows;
        logic [mpa_pkg::DIM_W-1:0]         cols;
        logic [mpa_pkg::CHCNT_W-1:0]       planes;
        logic signed [mpa_pkg::DATA_W-1:0] run_max [mpa_pkg::MAX_WIDTH];
        logic [mpa_pkg::IDX_W-1:0]         run_idx [mpa_pkg::MAX_WIDTH];
        int unsigned                       col, row, chan, col_ph, row_ph;
        pooled_t                           due [$];
        int                                mismatches;

        function new();
            win = 4'd2;
            rows = 9'd256;
            cols = 9'd256;
            planes = 7'd1;
            mismatches = 0;
            restart();
        endfunction

        function void restart();
            col = 0;
            row = 0;
            chan = 0;
            col_ph = 0;
            row_ph = 0;
        endfunction

        // A register write saturates its value and starts a new map;
        // writes to undecoded indexes change nothing.
        function void write_reg(logic [mpa_pkg::CFG_ADDR_W-1:0] addr,
                                logic [mpa_pkg::CFG_DATA_W-1:0] data);
            case (addr)
                mpa_pkg::REG_POOL_SIZE:
                    win = (data[3:0] == 0) ? 4'd1 :
                          (data[3:0] > mpa_pkg::MAX_POOL) ?
                              mpa_pkg::POOL_W'(mpa_pkg::MAX_POOL) : data[3:0];
                mpa_pkg::REG_FRAME_HEIGHT:
                    rows = (data == 0) ? 9'd1 :
                           (data > mpa_pkg::MAX_HEIGHT) ?
                               mpa_pkg::DIM_W'(mpa_pkg::MAX_HEIGHT) : data;
                mpa_pkg::REG_FRAME_WIDTH:
                    cols = (data == 0) ? 9'd1 :
                           (data > mpa_pkg::MAX_WIDTH) ?
                               mpa_pkg::DIM_W'(mpa_pkg::MAX_WIDTH) : data;
                mpa_pkg::REG_CHANNEL_COUNT:
                    planes = (data[6:0] == 0) ? 7'd1 :
                             (data[6:0] > mpa_pkg::MAX_CHANNELS) ?
                                 mpa_pkg::CHCNT_W'(mpa_pkg::MAX_CHANNELS) : data[6:0];
                default:
                    return;
            endcase
            restart();
        endfunction

        function int unsigned map_len();
            return int'(rows) * int'(cols) * int'(planes);
        endfunction

        // Fold one accepted pixel into its window; queue a pooled word when
        // the window's last in-bounds pixel has arrived.
        function void take_pixel(logic signed [mpa_pkg::DATA_W-1:0] v);
            int unsigned k, oc, idx;
            bit          col_end, row_end, row_last, plane_last, map_last;
            pooled_t     w;
            k = win;
            oc = (col / k) % mpa_pkg::MAX_WIDTH;
            idx = (chan * rows * cols + row * cols + col) & 32'h3F_FFFF;
            col_end = (col_ph + 1 >= k) || (col + 1 >= cols);
            row_end = (row_ph + 1 >= k) || (row + 1 >= rows);
            row_last = (col + 1 >= cols);
            plane_last = row_last && (row + 1 >= rows);
            map_last = plane_last && (chan + 1 >= planes);

            // The first pixel seeds the window; ties keep the earlier pixel.
            if ((col_ph == 0 && row_ph == 0) || v > run_max[oc]) begin
                run_max[oc] = v;
                run_idx[oc] = mpa_pkg::IDX_W'(idx);
            end
            if (col_end && row_end) begin
                w.value = run_max[oc];
                w.index = run_idx[oc];
                w.last = map_last;
                due.push_back(w);
            end

            // Step to the next raster position.
            if (row_last) begin
                col = 0;
                col_ph = 0;
                if (plane_last) begin
                    row = 0;
                    row_ph = 0;
                    chan = map_last ? 0 : chan + 1;
                end
                else begin
                    row = row + 1;
                    row_ph = (row_ph + 1 >= k) ? 0 : row_ph + 1;
                end
            end
            else begin
                col = col + 1;
                col_ph = (col_ph + 1 >= k) ? 0 : col_ph + 1;
            end
        endfunction

        // Compare one pooled word with the oldest one owed.
        function void check_pooled(logic [mpa_pkg::DATA_W-1:0] value,
                                   logic [mpa_pkg::IDX_W-1:0] index,
                                   logic last);
            pooled_t want;
            if (due.size() == 0) begin
                $display("%0t: unexpected word: pooled_value %0d winner_index %0d last %0b",
                         $time, $signed(value), index, last);
                mismatches++;
                return;
            end
            want = due.pop_front();
            if (value !== want.value) begin
                $display("%0t: pooled_value expected %0d got %0d",
                         $time, $signed(want.value), $signed(value));
                mismatches++;
            end
            if (index !== want.index) begin
                $display("%0t: winner_index expected %0d got %0d", $time, want.index, index);
                mismatches++;
            end
            if (last !== want.last) begin
                $display("%0t: last_of_map expected %0b got %0b", $time, want.last, last);
                mismatches++;
            end
        endfunction
    endclass

    pool_tracker tracker;

    max_pool_argmax DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_addr  (cfg_addr),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // Hard stop in case the block hangs or drops words.
    initial
    begin
        #1_000_000;
        $display("FAILURE");
        $finish;
    end

    // Receiver back-pressure.
    always @(negedge clk)
    begin
        m_tready <= ($urandom_range(0, 99) >= rx_idle_pct);
    end

    // Check every pooled word that the block hands over.
    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
            tracker.check_pooled(m_tdata[15:0], m_tdata[37:16], m_tlast);
    end

    // Send one pixel word; entered and left at a falling edge. Valid stays
    // high into the next word unless that word starts with a gap.
    task automatic send_pixel(input logic [mpa_pkg::DATA_W-1:0] v);
        while ($urandom_range(0, 99) < tx_idle_pct) begin
            s_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= v;
        do
            @(posedge clk);
        while (!s_tready);
        tracker.take_pixel(v);
        @(negedge clk);
    endtask

    // Write one register; the block is idle whenever this is called.
    task automatic cfg_write(input logic [mpa_pkg::CFG_ADDR_W-1:0] addr,
                             input logic [mpa_pkg::CFG_DATA_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_addr <= addr;
        cfg_data <= data;
        do
            @(posedge clk);
        while (!cfg_ready);
        tracker.write_reg(addr, data);
        @(negedge clk);
        cfg_valid <= 1'b0;
        @(negedge clk);
    endtask

    // Stop the pixel stream, collect every owed word, then let the pipeline empty.
    task automatic quiesce();
        s_tvalid <= 1'b0;
        while (tracker.due.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    initial
    begin
        logic [mpa_pkg::DATA_W-1:0]     tile [9];
        logic [mpa_pkg::CFG_DATA_W-1:0] k_raw, h_raw, w_raw, c_raw;
        int unsigned                    random_sent, n, span;

        tracker = new();
        rst_n = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        m_tready = 1'b0;
        cfg_valid = 1'b0;
        cfg_addr = '0;
        cfg_data = '0;
        tx_idle_pct = 33;
        rx_idle_pct = 87;

        repeat (11) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // 3x3 plane with 2x2 windows: cut-short edge windows, both extremes
        // and equal values where the earlier pixel must win.
        tile = '{16'h8000, 16'h8000, 16'd5,
                 16'h8000, 16'h7FFF, 16'h7FFF,
                 16'd7,    16'd7,    16'hFFFF};
        cfg_write(mpa_pkg::REG_POOL_SIZE, 9'd2);
        cfg_write(mpa_pkg::REG_FRAME_HEIGHT, 9'd3);
        cfg_write(mpa_pkg::REG_FRAME_WIDTH, 9'd3);
        cfg_write(mpa_pkg::REG_CHANNEL_COUNT, 9'd1);
        foreach (tile[i])
            send_pixel(tile[i]);
        quiesce();

        // Zero writes saturate up to one; undecoded writes in mid-map must not
        // restart the count, and the map wraps after its last pixel.
        cfg_write(mpa_pkg::REG_POOL_SIZE, 9'd0);
        cfg_write(mpa_pkg::REG_FRAME_HEIGHT, 9'd0);
        cfg_write(mpa_pkg::REG_FRAME_WIDTH, 9'd2);
        cfg_write(mpa_pkg::REG_CHANNEL_COUNT, 9'd0);
        send_pixel(16'h1234);
        quiesce();
        cfg_write(REG_UNUSED_LO, 9'h1AB);
        cfg_write(REG_UNUSED_HI, 9'h155);
        send_pixel(16'hEDCB);
        send_pixel(16'h0000);
        send_pixel(16'hFFFF);
        quiesce();

        // All-ones writes saturate to the largest sizes; a later write in
        // mid-map starts over from channel zero.
        cfg_write(mpa_pkg::REG_POOL_SIZE, 9'h1FF);
        cfg_write(mpa_pkg::REG_CHANNEL_COUNT, 9'h1FF);
        cfg_write(mpa_pkg::REG_FRAME_HEIGHT, 9'h1FF);
        cfg_write(mpa_pkg::REG_FRAME_WIDTH, 9'h1FF);
        send_pixel(16'h7FFF);
        send_pixel(16'hFFFF);
        send_pixel(16'h0001);
        quiesce();
        cfg_write(mpa_pkg::REG_FRAME_HEIGHT, 9'd1);
        cfg_write(mpa_pkg::REG_FRAME_WIDTH, 9'd1);
        send_pixel(16'h8000);
        send_pixel(16'h7FFF);
        send_pixel(16'h5555);
        send_pixel(16'hAAAA);
        quiesce();

        // Random maps: mostly whole maps with random shapes, sometimes cut
        // short, sometimes continued across an undecoded register write.
        random_sent = 0;
        while (random_sent < RANDOM_ITEMS) begin
            if (random_sent < 400) begin
                tx_idle_pct = 33;
                rx_idle_pct = 87;
            end
            else if (random_sent < 800) begin
                tx_idle_pct = 87;
                rx_idle_pct = 33;
            end
            else begin
                tx_idle_pct = 0;
                rx_idle_pct = 0;
            end

            if ($urandom_range(0, 11) == 0) begin
                cfg_write(mpa_pkg::CFG_ADDR_W'($urandom_range(4, 255)),
                          mpa_pkg::CFG_DATA_W'($urandom));
                n = $urandom_range(1, 60);
            end
            else begin
                case ($urandom_range(0, 9))
                    0: begin
                        // Widest rows.
                        k_raw = 9'($urandom_range(1, 8));
                        h_raw = 9'($urandom_range(1, 2));
                        w_raw = 9'($urandom_range(256, 511));
                        c_raw = 9'd1;
                    end
                    1: begin
                        // Tallest planes.
                        k_raw = 9'($urandom_range(1, 8));
                        h_raw = ($urandom_range(0, 1) == 0) ? 9'd256 : 9'($urandom);
                        w_raw = 9'($urandom_range(1, 2));
                        c_raw = 9'd1;
                    end
                    2: begin
                        // Most channels on tiny planes.
                        k_raw = 9'($urandom_range(1, 8));
                        h_raw = 9'($urandom_range(1, 2));
                        w_raw = 9'($urandom_range(1, 2));
                        c_raw = ($urandom_range(0, 1) == 0) ? 9'd64 : 9'($urandom);
                    end
                    3: begin
                        // Window sizes outside the usable range, zero dimensions.
                        k_raw = 9'($urandom);
                        h_raw = 9'($urandom_range(0, 10));
                        w_raw = 9'($urandom_range(0, 12));
                        c_raw = 9'($urandom_range(0, 3));
                    end
                    default: begin
                        k_raw = 9'($urandom_range(1, 8));
                        h_raw = 9'($urandom_range(1, 12));
                        w_raw = 9'($urandom_range(1, 24));
                        c_raw = 9'($urandom_range(1, 4));
                    end
                endcase
                cfg_write(mpa_pkg::REG_POOL_SIZE, k_raw);
                cfg_write(mpa_pkg::REG_FRAME_HEIGHT, h_raw);
                cfg_write(mpa_pkg::REG_FRAME_WIDTH, w_raw);
                cfg_write(mpa_pkg::REG_CHANNEL_COUNT, c_raw);
                span = tracker.map_len();
                n = span * $urandom_range(1, 2);
                if ($urandom_range(0, 3) == 0)
                    n = n + $urandom_range(0, span - 1);
                if (n > 600)
                    n = 600;
            end

            // Stop at the planned number of random words.
            if (n > RANDOM_ITEMS - random_sent)
                n = RANDOM_ITEMS - random_sent;

            repeat (n) begin
                case ($urandom_range(0, 9))
                    0:       send_pixel(16'h8000);
                    1:       send_pixel(16'h7FFF);
                    2, 3:    send_pixel(16'($urandom_range(0, 8)) - 16'd4);
                    default: send_pixel(16'($urandom));
                endcase
            end
            random_sent += n;
            quiesce();
        end

        if (tracker.mismatches == 0 && tracker.due.size() == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
